// ===== design/upd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam int unsigned SLOTS        = 3;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } t_out_word;

    // All words that one input item produces, oldest in slot 0.
    typedef struct packed {
        logic [1:0]            count;
        t_out_word [SLOTS-1:0] slot;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h41 + 8'd10;
        end
        hex_value = v[3:0];
    endfunction

endpackage

// ===== design/url_percent_decoder_top.sv =====
// Streaming URL percent decoder: one encoded byte in per cycle while the queue is not full,
// decoded words out through a queue-style port. Each accepted byte yields zero to three words:
// a plain or decoded byte, a held hex digit flushed ahead of the next character, and a
// terminator word after the byte flagged as last. A byte is taken every cycle while each byte
// yields at most one word and words are popped; a byte that yields two or three words holds
// the back end longer, and the bundle queue (P_QUEUE_DEPTH entries) absorbs such bursts before
// full rises. A bundle is written into the queue, then its words are registered at the output.
module url_percent_decoder_top import upd_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_word  i_item,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_word
);

    logic      q_push, q_pop;
    t_bundle   q_in, q_out;
    t_q_status q_status;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_full     (o_full),
        .o_q_push   (q_push),
        .o_q_bundle (q_in)
    );

    upd_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .i_pop    (q_pop),
        .o_bundle (q_out),
        .o_status (q_status)
    );

    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_bundle (q_out),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_word     (o_word)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("bundle popped from an empty queue");

    a_bundle_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.count != 2'd0))
        else $error("empty bundle pushed");

    a_last_terminates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_item.in_last) |-> (q_push && q_in.slot[q_in.count - 2'd1].out_end))
        else $error("last byte did not produce a terminator word");

endmodule

// ===== design/upd_front.sv =====
// Front end: accepts encoded bytes, tracks escape state and builds one word bundle per byte.
module upd_front import upd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_word  i_item,
    input  t_q_status i_q_status,
    output logic      o_full,
    output logic      o_q_push,
    output t_bundle   o_q_bundle
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;

    assign o_full = i_q_status.full;
    assign accept = i_push && !i_q_status.full;

    always_comb begin
        logic [7:0] c;
        logic [7:0] pb;
        logic       pct;
        logic [1:0] cnt;
        t_bundle    b;

        c   = i_item.in_byte;
        pct = (c == CH_PERCENT);
        pb  = (c == CH_PLUS || c == CH_UNDERSCORE) ? CH_SPACE : c;
        cnt = 2'd0;
        b   = '0;
        n_phase = r_phase;
        n_held  = r_held;

        case (r_phase)
            PH_PCT: begin
                if (is_hex(c)) begin
                    n_held  = c;
                    n_phase = PH_DIGIT;
                end else if (pct) begin
                    n_phase = PH_PCT;
                end else begin
                    b.slot[cnt] = '{out_byte: pb, out_end: 1'b0};
                    cnt = cnt + 2'd1;
                    n_phase = PH_PLAIN;
                end
            end
            PH_DIGIT: begin
                if (is_hex(c)) begin
                    b.slot[cnt] = '{out_byte: {hex_value(r_held), hex_value(c)}, out_end: 1'b0};
                    cnt = cnt + 2'd1;
                    n_phase = PH_PLAIN;
                end else begin
                    // lone digit goes through as it came
                    b.slot[cnt] = '{out_byte: r_held, out_end: 1'b0};
                    cnt = cnt + 2'd1;
                    if (pct) begin
                        n_phase = PH_PCT;
                    end else begin
                        b.slot[cnt] = '{out_byte: pb, out_end: 1'b0};
                        cnt = cnt + 2'd1;
                        n_phase = PH_PLAIN;
                    end
                end
                n_held = CH_NUL;
            end
            default: begin
                if (pct) begin
                    n_phase = PH_PCT;
                end else begin
                    b.slot[cnt] = '{out_byte: pb, out_end: 1'b0};
                    cnt = cnt + 2'd1;
                    n_phase = PH_PLAIN;
                end
            end
        endcase

        if (i_item.in_last) begin
            // flush a held digit, drop a bare percent, then terminate
            if (n_phase == PH_DIGIT) begin
                b.slot[cnt] = '{out_byte: n_held, out_end: 1'b0};
                cnt = cnt + 2'd1;
            end
            b.slot[cnt] = '{out_byte: CH_NUL, out_end: 1'b1};
            cnt = cnt + 2'd1;
            n_phase = PH_PLAIN;
            n_held  = CH_NUL;
        end

        b.count    = cnt;
        o_q_bundle = b;
    end

    assign o_q_push = accept && (o_q_bundle.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_held  <= CH_NUL;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== design/upd_queue.sv =====
// Small bundle queue between the front and back ends.
module upd_queue import upd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bundle   i_bundle,
    input  logic      i_pop,
    output t_bundle   o_bundle,
    output t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_slots [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_bundle       = r_slots[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/upd_back.sv =====
// Back end: walks each bundle one word at a time into the output register.
module upd_back import upd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_q_bundle,
    input  t_q_status i_q_status,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_word
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_word  r_word;
    t_out_word  head_word;
    logic       load, take, last_slot;

    always_comb begin
        case (r_idx)
            2'd0:    head_word = i_q_bundle.slot[0];
            2'd1:    head_word = i_q_bundle.slot[1];
            2'd2:    head_word = i_q_bundle.slot[2];
            default: head_word = i_q_bundle.slot[0];
        endcase
    end

    assign load      = !r_valid || i_pop;
    assign take      = load && !i_q_status.empty;
    assign last_slot = (r_idx == i_q_bundle.count - 2'd1);
    assign o_q_pop   = take && last_slot;
    assign o_empty   = !r_valid;
    assign o_word    = r_word;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= head_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (take) begin
                // advance within the bundle, rewind when it is used up
                r_idx <= last_slot ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== sim/url_percent_decoder_top_test.sv =====
// Self-checking testbench for url_percent_decoder_top: directed and random encoded strings.
module url_percent_decoder_top_test;
    import upd_pkg::*;

    localparam int unsigned ITEM_TARGET = 320;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef logic [7:0] t_byte_q[$];

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    t_in_word  i_item;
    logic      o_full;
    logic      o_empty;
    logic      i_pop;
    t_out_word o_word;

    // Decoder state mirrored by the testbench
    t_phase     esc_phase;
    logic [7:0] held_char;
    t_out_word  decoded_q[$];

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned rx_hold_cycles;
    bit          tx_paced;
    bit          rx_paced;
    bit          rst_done;

    url_percent_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_word  (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // {is hex digit, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic int unsigned pick_gap(input bit paced);
        if (!paced || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch: %s got %h want %h", what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic expect_word(input logic [7:0] b, input logic e);
        t_out_word w;
        w.out_byte = b;
        w.out_end  = e;
        decoded_q.push_back(w);
    endtask

    task automatic model_plain(input logic [7:0] c);
        if (c == CH_PERCENT) begin
            esc_phase = PH_PCT;
        end else begin
            esc_phase = PH_PLAIN;
            expect_word((c == CH_PLUS || c == CH_UNDERSCORE) ? CH_SPACE : c, 1'b0);
        end
    endtask

    // Advance the decoder state by one byte and queue the words it yields.
    task automatic model_byte(input t_in_word w);
        logic [4:0] d;
        logic [4:0] h;
        d = hex_digit(w.in_byte);
        case (esc_phase)
            PH_PCT: begin
                if (d[4]) begin
                    held_char = w.in_byte;
                    esc_phase = PH_DIGIT;
                end else begin
                    model_plain(w.in_byte);
                end
            end
            PH_DIGIT: begin
                if (d[4]) begin
                    h = hex_digit(held_char);
                    expect_word({h[3:0], d[3:0]}, 1'b0);
                    esc_phase = PH_PLAIN;
                end else begin
                    expect_word(held_char, 1'b0);
                    model_plain(w.in_byte);
                end
                if (esc_phase != PH_DIGIT) begin
                    held_char = 8'h00;
                end
            end
            default: model_plain(w.in_byte);
        endcase
        if (w.in_last) begin
            if (esc_phase == PH_DIGIT) begin
                expect_word(held_char, 1'b0);
            end
            expect_word(CH_NUL, 1'b1);
            esc_phase = PH_PLAIN;
            held_char = 8'h00;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        t_in_word    w;
        gap = pick_gap(tx_paced);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.in_byte = b;
        w.in_last = last;
        i_push <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (o_full !== 1'b0);
        model_byte(w);
        items_sent++;
    endtask

    task automatic send_bytes(input t_byte_q s);
        foreach (s[i]) begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Hold the input until every queued word has been popped.
    task automatic wait_until_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            return CH_PERCENT;
        end
        do c = 8'($urandom_range(1, 255)); while (hex_digit(c) != 5'd0);
        return c;
    endfunction

    // Well-formed escapes with random content, plus and underscore, broken escapes, lone percents and noise.
    function automatic t_byte_q build_string();
        t_byte_q     s;
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    s.push_back(CH_PERCENT);
                    s.push_back(pick_hex());
                    s.push_back(pick_hex());
                end
                3: s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_UNDERSCORE);
                4: begin
                    s.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1)) begin
                        s.push_back(pick_hex());
                    end
                    s.push_back(pick_non_hex());
                end
                5: s.push_back(CH_PERCENT);
                default: s.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        return s;
    endfunction

    task automatic test_directed();
        tx_paced = 1'b1;
        rx_paced = 1'b1;
        send_text("+_%00%fF");
        // escape after escape, held digit then percent, broken escapes, lone trailing percent
        send_text("%%4%7zG%");
        send_text("%A");
        send_byte(CH_PERCENT, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_PERCENT, 1'b0);
        send_byte(8'h39, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        wait_until_drained();
    endtask

    task automatic test_backpressure();
        tx_paced = 1'b0;
        rx_hold_cycles = 80;
        while (items_sent < 80) begin
            send_bytes(build_string());
        end
        tx_paced = 1'b1;
        wait_until_drained();
    endtask

    task automatic test_pause_per_string();
        rx_paced = 1'b1;
        repeat (4) begin
            send_bytes(build_string());
            wait_until_drained();
        end
    endtask

    task automatic test_random_strings();
        int unsigned strings;
        strings = 0;
        while (items_sent < ITEM_TARGET) begin
            if (strings % 8 == 0) begin
                tx_paced = ($urandom_range(0, 3) != 0);
                rx_paced = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_until_drained();
            end
            send_bytes(build_string());
            strings++;
        end
        wait_until_drained();
    endtask

    // Result side: pop each word after a drawn stall, with a long hold when the backpressure test asks for one.
    initial begin : pop_side
        int unsigned stall;
        int unsigned held;
        i_pop <= 1'b0;
        wait (rst_done);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_pop <= 1'b0;
                for (held = 0; held < rx_hold_cycles; held++) begin
                    @(posedge i_clk);
                end
                rx_hold_cycles = 0;
            end
            stall = pick_gap(rx_paced);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty !== 1'b0);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && i_pop && o_empty === 1'b0) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("word with nothing expected", o_word, 9'd0);
            end else begin
                want = decoded_q.pop_front();
                if (o_word.out_end !== want.out_end) begin
                    report_mismatch("out_end", o_word, want);
                end else if (!want.out_end && o_word.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_word, want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && o_full === 1'b0) || (i_pop && o_empty === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL url_percent_decoder_top");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        rx_hold_cycles = 0;
        tx_paced       = 1'b1;
        rx_paced       = 1'b1;
        rst_done       = 1'b0;
        esc_phase      = PH_PLAIN;
        held_char      = 8'h00;
        i_rst_n <= 1'b0;
        i_push  <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        test_directed();
        test_backpressure();
        test_pause_per_string();
        test_random_strings();

        // Let any stray words surface before the verdict.
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS url_percent_decoder_top");
        end else begin
            $display("FAIL url_percent_decoder_top");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/upd_pkg.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder_top.sv
sim/url_percent_decoder_top_test.sv
